/* rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray/sphere intersection block
// Payload structs for the ray and result channels, configuration register
// indexes and saturation limits.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int COORD_W    = 32;
  localparam int NORM_W     = 16;
  localparam int RAD_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // coordinate format is Q16.16; the datapath is scale free, so this only
  // names the format
  localparam int COORD_FRAC_BITS = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_t;

  // radius after reset: 1.0 in Q16.16
  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;

  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
  } out_t;

endpackage

/* rtl/rsi_isqrt.sv */
// ----------------------------------------------------------------------------
// rsi_isqrt: pipelined integer square root
// floor(sqrt(x)) one root bit per stage, XW/2 stages; a side payload and a
// valid bit travel with each operand. All stages advance on en.
// ----------------------------------------------------------------------------
module rsi_isqrt #(
  parameter int XW = 126,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  logic [XW-1:0]   x_i,
  input  logic [PW-1:0]   pay_i,
  output logic            v_o,
  output logic [XW/2-1:0] root_o,
  output logic [PW-1:0]   pay_o
);

  localparam int RW   = XW / 2;
  localparam int REMW = RW + 1;

  logic [RW-1:0]   root_r [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [XW-1:0]   xs_r   [RW];
  logic [PW-1:0]   pay_r  [RW];
  logic [RW-1:0]   v_r;

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RW-1:0]   root_in;
    logic [REMW-1:0] rem_in;
    logic [XW-1:0]   xs_in;
    logic [PW-1:0]   pay_in;
    logic            v_in;
    logic [RW+2:0]   t;
    logic [RW+2:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign xs_in   = x_i;
      assign pay_in  = pay_i;
      assign v_in    = v_i;
    end else begin : g_next
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign xs_in   = xs_r[k-1];
      assign pay_in  = pay_r[k-1];
      assign v_in    = v_r[k-1];
    end

    // bring down two bits, try (4*root + 1)
    assign t     = {rem_in, xs_in[XW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[RW-2:0], ge};
        rem_r[k]  <= ge ? REMW'(t - trial) : REMW'(t);
        xs_r[k]   <= xs_in << 2;
        pay_r[k]  <= pay_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end
  end

  assign v_o    = v_r[RW-1];
  assign root_o = root_r[RW-1];
  assign pay_o  = pay_r[RW-1];

endmodule

/* rtl/rsi_div.sv */
// ----------------------------------------------------------------------------
// rsi_div: pipelined restoring divider
// QW quotient bits of num/den, one bit per stage after an entry stage that
// flags a quotient too wide for QW bits. Payload and valid travel along.
// ----------------------------------------------------------------------------
module rsi_div #(
  parameter int NW = 97,
  parameter int DW = 64,
  parameter int QW = 34,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          v_o,
  output logic [QW-1:0] q_o,
  output logic          ovf_o,
  output logic [PW-1:0] pay_o
);

  localparam int HW = NW - QW;
  localparam int MW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic          ovf_r [QW+1];
  logic [PW-1:0] pay_r [QW+1];
  logic [QW:0]   v_r;

  logic [HW-1:0] hi;
  assign hi = num_i[NW-1:QW];

  // entry stage: upper part must stay below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(hi);
      lo_r[0]  <= num_i[QW-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den_i;
      ovf_r[0] <= (MW'(hi) >= MW'(den_i));
      pay_r[0] <= pay_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_st
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    assign t    = {rem_r[k-1], lo_r[k-1][QW-1]};
    assign diff = t - {1'b0, den_r[k-1]};
    assign ge   = (t >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        q_r[k]   <= {q_r[k-1][QW-2:0], ge};
        lo_r[k]  <= lo_r[k-1] << 1;
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        pay_r[k] <= pay_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  assign v_o   = v_r[QW];
  assign q_o   = q_r[QW];
  assign ovf_o = ovf_r[QW];
  assign pay_o = pay_r[QW];

endmodule

/* rtl/ray_sphere_intersect.sv */
// ----------------------------------------------------------------------------
// ray_sphere_intersect: fixed-point ray/sphere hit point and surface normal
// Depth: the two 63-stage square roots and the 35- and 16-stage dividers make up
//   most of the register stages from an accepted ray to out_valid.
// Throughput: one ray per cycle; the whole pipeline holds while a result
//   waits at the output register.
// Reset: synchronous, active low; clears valid bits, center to 0, radius 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rsi_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rsi_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import rsi_pkg::*;

  typedef struct packed {
    logic             miss;
    logic [65:0]      h;
    logic [63:0]      a;
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
  } sp1_t;

  typedef struct packed {
    logic        miss;
    logic        dneg;
    logic [31:0] o;
  } dp1_t;

  typedef struct packed {
    logic             miss;
    logic [2:0][31:0] p;
    logic [2:0][32:0] mag;
    logic [2:0]       sgn;
  } sp2_t;

  typedef struct packed {
    logic        miss;
    logic        lz;
    logic        sgn;
    logic [31:0] p;
  } dp2_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-$signed(v)) : v;
    return r;
  endfunction

  logic en;

  // configuration registers
  logic signed [31:0] ctr_r [3];
  logic [RAD_W-1:0]   rad_r;
  logic [61:0]        r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      rad_r    <= RADIUS_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: ctr_r[0] <= cfg_data;
        CFG_CENTER_Y: ctr_r[1] <= cfg_data;
        CFG_CENTER_Z: ctr_r[2] <= cfg_data;
        CFG_RADIUS:   rad_r    <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // r^2 follows the radius register
  always_ff @(posedge clk) begin
    r2_r <= 62'(rad_r) * 62'(rad_r);
  end

  assign cfg_ready = 1'b1;

  // global advance: output register empty or being drained
  logic out_valid_r;
  out_t out_data_r;
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic [31:0] in_o [3];
  logic [31:0] in_d [3];
  assign in_o[0] = in_data.origin_x;
  assign in_o[1] = in_data.origin_y;
  assign in_o[2] = in_data.origin_z;
  assign in_d[0] = in_data.dir_x;
  assign in_d[1] = in_data.dir_y;
  assign in_d[2] = in_data.dir_z;

  // valid bits of the inline stages
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic v8_r, v9_r, v10_r, v11_r, v12_r, v13_r, v14_r, v15_r;
  logic vs1, vd1_w [3], vs2, vd2_w [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      v9_r <= 1'b0; v10_r <= 1'b0; v11_r <= 1'b0; v12_r <= 1'b0;
      v13_r <= 1'b0; v14_r <= 1'b0; v15_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
      v8_r <= vs1; v9_r <= v8_r; v10_r <= v9_r;
      v11_r <= vd1_w[0]; v12_r <= v11_r; v13_r <= v12_r; v14_r <= v13_r;
      v15_r <= vs2;
      out_valid_r <= vd2_w[0];
    end
  end

  // stage 1: w = o - c
  logic [2:0][31:0]   o1_r, d1_r;
  logic signed [32:0] w1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_r[i] <= in_o[i];
        d1_r[i] <= in_d[i];
        w1_r[i] <= 33'($signed(in_o[i])) - 33'(ctr_r[i]);
      end
    end
  end

  // stage 2: cross, dot and |d|^2 products
  logic signed [64:0] ca2_r [3];
  logic signed [64:0] cb2_r [3];
  logic signed [64:0] dt2_r [3];
  logic [62:0]        dsq2_r [3];
  logic [2:0][31:0]   o2_r, d2_r;

  for (genvar i = 0; i < 3; i++) begin : g_s2
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic [63:0] dsq;
    assign dsq = 64'(mag32(d1_r[i])) * 64'(mag32(d1_r[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        ca2_r[i]  <= 65'($signed(d1_r[J])) * 65'(w1_r[K]);
        cb2_r[i]  <= 65'($signed(d1_r[K])) * 65'(w1_r[J]);
        dt2_r[i]  <= 65'($signed(d1_r[i])) * 65'(w1_r[i]);
        dsq2_r[i] <= dsq[62:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o2_r <= o1_r;
      d2_r <= d1_r;
    end
  end

  // stage 3: e = d x w, h = d.w, a = |d|^2
  logic signed [65:0] e3_r [3];
  logic signed [65:0] h3_r;
  logic [63:0]        a3_r;
  logic [2:0][31:0]   o3_r, d3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e3_r[i] <= 66'(ca2_r[i]) - 66'(cb2_r[i]);
      end
      h3_r <= 66'(dt2_r[0]) + 66'(dt2_r[1]) + 66'(dt2_r[2]);
      a3_r <= 64'(dsq2_r[0]) + 64'(dsq2_r[1]) + 64'(dsq2_r[2]);
      o3_r <= o2_r;
      d3_r <= d2_r;
    end
  end

  // stage 4: |e|, oversize check, a*r^2 partial products
  logic [65:0]      em [3];
  logic [62:0]      m4_r [3];
  logic             big4_r;
  logic [63:0]      pall4_r, pahl4_r;
  logic [61:0]      palh4_r, pahh4_r;
  logic [63:0]      a4_r;
  logic [65:0]      h4_r;
  logic [2:0][31:0] o4_r, d4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      em[i] = e3_r[i][65] ? 66'(-e3_r[i]) : 66'(e3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m4_r[i] <= em[i][62:0];
      end
      big4_r  <= (|em[0][65:63]) | (|em[1][65:63]) | (|em[2][65:63]);
      pall4_r <= 64'(a3_r[31:0]) * 64'(r2_r[31:0]);
      palh4_r <= 62'(a3_r[31:0]) * 62'(r2_r[61:32]);
      pahl4_r <= 64'(a3_r[63:32]) * 64'(r2_r[31:0]);
      pahh4_r <= 62'(a3_r[63:32]) * 62'(r2_r[61:32]);
      a4_r    <= a3_r;
      h4_r    <= h3_r;
      o4_r    <= o3_r;
      d4_r    <= d3_r;
    end
  end

  // stage 5: |e|^2 partials, a*r^2 sum
  logic [63:0]      sl5_r [3];
  logic [62:0]      sx5_r [3];
  logic [61:0]      sh5_r [3];
  logic [125:0]     ar2_5_r;
  logic             big5_r;
  logic [63:0]      a5_r;
  logic [65:0]      h5_r;
  logic [2:0][31:0] o5_r, d5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sl5_r[i] <= 64'(m4_r[i][31:0]) * 64'(m4_r[i][31:0]);
        sx5_r[i] <= 63'(m4_r[i][31:0]) * 63'(m4_r[i][62:32]);
        sh5_r[i] <= 62'(m4_r[i][62:32]) * 62'(m4_r[i][62:32]);
      end
      ar2_5_r <= 126'(pall4_r) + (126'(palh4_r) << 32) + (126'(pahl4_r) << 32)
               + (126'(pahh4_r) << 64);
      big5_r  <= big4_r;
      a5_r    <= a4_r;
      h5_r    <= h4_r;
      o5_r    <= o4_r;
      d5_r    <= d4_r;
    end
  end

  // stage 6: full squares
  logic [125:0]     sq6_r [3];
  logic [125:0]     ar2_6_r;
  logic             big6_r;
  logic [63:0]      a6_r;
  logic [65:0]      h6_r;
  logic [2:0][31:0] o6_r, d6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= 126'(sl5_r[i]) + (126'(sx5_r[i]) << 33) + (126'(sh5_r[i]) << 64);
      end
      ar2_6_r <= ar2_5_r;
      big6_r  <= big5_r;
      a6_r    <= a5_r;
      h6_r    <= h5_r;
      o6_r    <= o5_r;
      d6_r    <= d5_r;
    end
  end

  // stage 7: discriminant a*r^2 - |d x w|^2 and early miss
  logic [127:0]     sum7;
  logic [125:0]     disc7_r;
  sp1_t             sp1_7_r;

  assign sum7 = 128'(sq6_r[0]) + 128'(sq6_r[1]) + 128'(sq6_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      disc7_r      <= 126'(128'(ar2_6_r) - sum7);
      sp1_7_r.miss <= (a6_r == '0) || big6_r || (sum7 > 128'(ar2_6_r));
      sp1_7_r.h    <= h6_r;
      sp1_7_r.a    <= a6_r;
      sp1_7_r.o    <= o6_r;
      sp1_7_r.d    <= d6_r;
    end
  end

  // square root of the discriminant
  logic [62:0] s_root;
  sp1_t        sp1_o;

  rsi_isqrt #(
    .XW (126),
    .PW ($bits(sp1_t))
  ) u_sqrt_disc (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (v7_r),
    .x_i    (disc7_r),
    .pay_i  (sp1_7_r),
    .v_o    (vs1),
    .root_o (s_root),
    .pay_o  (sp1_o)
  );

  // stage 8: root numerators, nearest positive one
  logic signed [67:0] nh, sx68, n0, n1;
  logic               pos0, pos1;
  logic [64:0]        num8_r;
  logic               miss8_r;
  logic [63:0]        a8_r;
  logic [2:0][31:0]   o8_r, d8_r;

  always_comb begin
    nh   = -68'($signed(sp1_o.h));
    sx68 = $signed({5'b0, s_root});
    n0   = nh - sx68;
    n1   = nh + sx68;
    pos0 = !n0[67] && (n0 != '0);
    pos1 = !n1[67] && (n1 != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num8_r  <= pos0 ? n0[64:0] : n1[64:0];
      miss8_r <= sp1_o.miss || !(pos0 || pos1);
      a8_r    <= sp1_o.a;
      o8_r    <= sp1_o.o;
      d8_r    <= sp1_o.d;
    end
  end

  // stage 9: num*|d| partials
  logic [63:0]      pl9_r [3];
  logic [64:0]      ph9_r [3];
  logic [2:0]       dneg9_r;
  logic             miss9_r;
  logic [63:0]      a9_r;
  logic [2:0][31:0] o9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl9_r[i]   <= 64'(num8_r[31:0]) * 64'(mag32(d8_r[i]));
        ph9_r[i]   <= 65'(num8_r[64:32]) * 65'(mag32(d8_r[i]));
        dneg9_r[i] <= d8_r[i][31];
      end
      miss9_r <= miss8_r;
      a9_r    <= a8_r;
      o9_r    <= o8_r;
    end
  end

  // stage 10: rounded dividend num*|d| + a/2
  logic [96:0] n10_r [3];
  logic [63:0] a10_r;
  dp1_t        dp1_in [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n10_r[i]       <= 97'(pl9_r[i]) + (97'(ph9_r[i]) << 32) + 97'(a9_r[63:1]);
        dp1_in[i].miss <= miss9_r;
        dp1_in[i].dneg <= dneg9_r[i];
        dp1_in[i].o    <= o9_r[i];
      end
      a10_r <= a9_r;
    end
  end

  // per-axis distance along the ray: round(num*|d|/a)
  logic [33:0] q1   [3];
  logic        ovf1 [3];
  dp1_t        dp1_o [3];

  for (genvar i = 0; i < 3; i++) begin : g_div1
    rsi_div #(
      .NW (97),
      .DW (64),
      .QW (34),
      .PW ($bits(dp1_t))
    ) u_div_t (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (v10_r),
      .num_i (n10_r[i]),
      .den_i (a10_r),
      .pay_i (dp1_in[i]),
      .v_o   (vd1_w[i]),
      .q_o   (q1[i]),
      .ovf_o (ovf1[i]),
      .pay_o (dp1_o[i])
    );
  end

  // stage 11: hit point with saturation
  logic signed [35:0] ov36 [3];
  logic signed [35:0] qv36 [3];
  logic signed [35:0] sv36 [3];
  logic [2:0][31:0]   p_nxt;
  logic [2:0][31:0]   p11_r;
  logic               miss11_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ov36[i] = 36'($signed(dp1_o[i].o));
      qv36[i] = $signed({2'b0, q1[i]});
      sv36[i] = dp1_o[i].dneg ? (ov36[i] - qv36[i]) : (ov36[i] + qv36[i]);
      if (ovf1[i]) begin
        p_nxt[i] = dp1_o[i].dneg ? SAT_MIN : SAT_MAX;
      end else if (sv36[i] > 36'(SAT_MAX)) begin
        p_nxt[i] = SAT_MAX;
      end else if (sv36[i] < 36'(SAT_MIN)) begin
        p_nxt[i] = SAT_MIN;
      end else begin
        p_nxt[i] = sv36[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p11_r    <= p_nxt;
      miss11_r <= dp1_o[0].miss;
    end
  end

  // stage 12: v = P - c, magnitude and sign
  logic signed [32:0] wn [3];
  logic [2:0][32:0]   mag12_r;
  logic [2:0]         sgn12_r;
  logic [2:0][31:0]   p12_r;
  logic               miss12_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wn[i] = 33'($signed(p11_r[i])) - 33'(ctr_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag12_r[i] <= wn[i][32] ? 33'(-wn[i]) : 33'(wn[i]);
        sgn12_r[i] <= wn[i][32];
      end
      p12_r    <= p11_r;
      miss12_r <= miss11_r;
    end
  end

  // stage 13: squares of v
  logic [65:0]      vsq13_r [3];
  logic [2:0][32:0] mag13_r;
  logic [2:0]       sgn13_r;
  logic [2:0][31:0] p13_r;
  logic             miss13_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vsq13_r[i] <= 66'(mag12_r[i]) * 66'(mag12_r[i]);
      end
      mag13_r  <= mag12_r;
      sgn13_r  <= sgn12_r;
      p13_r    <= p12_r;
      miss13_r <= miss12_r;
    end
  end

  // stage 14: |v|^2
  logic [65:0] s2_14_r;
  sp2_t        sp2_14_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_14_r       <= vsq13_r[0] + vsq13_r[1] + vsq13_r[2];
      sp2_14_r.miss <= miss13_r;
      sp2_14_r.p    <= p13_r;
      sp2_14_r.mag  <= mag13_r;
      sp2_14_r.sgn  <= sgn13_r;
    end
  end

  // length of v scaled by 2^30
  logic [62:0] len_root;
  sp2_t        sp2_o;

  rsi_isqrt #(
    .XW (126),
    .PW ($bits(sp2_t))
  ) u_sqrt_len (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (v14_r),
    .x_i    ({s2_14_r, 60'b0}),
    .pay_i  (sp2_14_r),
    .v_o    (vs2),
    .root_o (len_root),
    .pay_o  (sp2_o)
  );

  // stage 15: normal dividends |v_i|*2^44 + len/2
  logic [77:0] n15_r [3];
  logic [62:0] len15_r;
  dp2_t        dp2_in [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n15_r[i]       <= 78'({sp2_o.mag[i], 44'b0}) + 78'(len_root[62:1]);
        dp2_in[i].miss <= sp2_o.miss;
        dp2_in[i].lz   <= (len_root == '0);
        dp2_in[i].sgn  <= sp2_o.sgn[i];
        dp2_in[i].p    <= sp2_o.p[i];
      end
      len15_r <= len_root;
    end
  end

  // normal components, 15 quotient bits
  logic [14:0] q2    [3];
  logic        ovf2  [3];
  dp2_t        dp2_o [3];

  for (genvar i = 0; i < 3; i++) begin : g_div2
    rsi_div #(
      .NW (78),
      .DW (63),
      .QW (15),
      .PW ($bits(dp2_t))
    ) u_div_n (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (v15_r),
      .num_i (n15_r[i]),
      .den_i (len15_r),
      .pay_i (dp2_in[i]),
      .v_o   (vd2_w[i]),
      .q_o   (q2[i]),
      .ovf_o (ovf2[i]),
      .pay_o (dp2_o[i])
    );
  end

  // output assembly; a miss clears every field, a zero length or a divider overflow clears normals
  logic [15:0] nrm [3];
  logic [15:0] nq  [3];
  out_t        out_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i] = {1'b0, q2[i]};
      if (dp2_o[i].miss || dp2_o[i].lz || ovf2[i]) begin
        nrm[i] = '0;
      end else begin
        nrm[i] = dp2_o[i].sgn ? 16'(-nq[i]) : nq[i];
      end
    end
    out_nxt.hit      = !dp2_o[0].miss;
    out_nxt.hit_x    = dp2_o[0].miss ? '0 : dp2_o[0].p;
    out_nxt.hit_y    = dp2_o[0].miss ? '0 : dp2_o[1].p;
    out_nxt.hit_z    = dp2_o[0].miss ? '0 : dp2_o[2].p;
    out_nxt.normal_x = nrm[0];
    out_nxt.normal_y = nrm[1];
    out_nxt.normal_z = nrm[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

/* rtl/rsi_chk.sv */
// ----------------------------------------------------------------------------
// rsi_chk: port-level checks for ray_sphere_intersect
// Watches the result channel and the input ready; bound to the top level.
// ----------------------------------------------------------------------------
module rsi_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rsi_pkg::out_t out_data
);

  import rsi_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // empty output register never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_x == '0 && out_data.hit_y == '0
      && out_data.hit_z == '0 && out_data.normal_x == '0
      && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("miss with nonzero fields");

  // unit normal components stay within one
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384
      && out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384
      && out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384)
    else $error("normal out of range");

endmodule

bind ray_sphere_intersect rsi_chk u_rsi_chk (.*);

/* sim/ray_sphere_checker.sv */
// ----------------------------------------------------------------------------
// ray_sphere_checker: scoreboard for the ray/sphere intersection block
// Watches the configuration, ray and result channels. Keeps its own copy of
// the sphere registers, predicts each result from the accepted ray with exact
// wide integer arithmetic and compares every result field in order.
// ----------------------------------------------------------------------------
module ray_sphere_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rsi_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rsi_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import rsi_pkg::*;

  // sphere registers as seen by the block
  longint sph_cx, sph_cy, sph_cz, sph_rad;
  out_t   hits_due[$];

  // floor square root of a 128-bit value
  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (sq <= n) root = cand;
    end
    return root;
  endfunction

  function automatic logic [63:0] mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // expected result of one ray against the current sphere
  function automatic out_t intersect_ray(in_t ray);
    longint                o[3], d[3], c[3], w[3], pt[3];
    longint                v, dq;
    logic [63:0]           a, s, len, m;
    logic signed [127:0]   dd[3], ww[3], e[3], h, n0, n1, num, ss, am;
    logic [127:0]          sum, ar2, disc, mm, prod, q, s2, rr;
    logic signed [15:0]    nrm[3];
    logic signed [63:0]    nv;
    out_t                  r;
    r = '0;
    c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
    o[0] = ray.origin_x; o[1] = ray.origin_y; o[2] = ray.origin_z;
    d[0] = ray.dir_x;    d[1] = ray.dir_y;    d[2] = ray.dir_z;
    a = '0;
    for (int i = 0; i < 3; i++) begin
      w[i]  = o[i] - c[i];
      dd[i] = d[i];
      ww[i] = w[i];
      m     = mag(d[i]);
      a     = a + m * m;
    end
    // zero direction
    if (a == 0) return r;

    // discriminant a*r^2 - |d x w|^2
    e[0] = dd[1] * ww[2] - dd[2] * ww[1];
    e[1] = dd[2] * ww[0] - dd[0] * ww[2];
    e[2] = dd[0] * ww[1] - dd[1] * ww[0];
    rr   = sph_rad * sph_rad;
    ar2  = {64'd0, a} * rr;
    sum  = '0;
    for (int i = 0; i < 3; i++) begin
      am = (e[i] < 0) ? -e[i] : e[i];
      mm = am;
      if (mm >= (128'd1 << 63)) return r;
      sum = sum + mm * mm;
    end
    if (sum > ar2) return r;
    disc = ar2 - sum;
    s    = isqrt128(disc);

    // nearest strictly positive root numerator
    h  = dd[0] * ww[0] + dd[1] * ww[1] + dd[2] * ww[2];
    ss = {64'd0, s};
    n0 = -h - ss;
    n1 = -h + ss;
    if (n0 > 0) num = n0;
    else if (n1 > 0) num = n1;
    else return r;

    // hit point, rounded half away from zero, saturated
    for (int i = 0; i < 3; i++) begin
      m    = mag(d[i]);
      prod = num;
      prod = prod * {64'd0, m};
      q    = (prod + {65'd0, a[63:1]}) / {64'd0, a};
      if (q >= (128'd1 << 34)) begin
        pt[i] = (d[i] < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
        dq = q[63:0];
        v  = o[i] + ((d[i] < 0) ? -dq : dq);
        pt[i] = (v > 64'sd2147483647) ? 64'sd2147483647 :
                (v < -64'sd2147483648) ? -64'sd2147483648 : v;
      end
    end
    r.hit   = 1'b1;
    r.hit_x = pt[0][31:0];
    r.hit_y = pt[1][31:0];
    r.hit_z = pt[2][31:0];

    // unit normal from the saturated point
    s2 = '0;
    for (int i = 0; i < 3; i++) begin
      w[i] = pt[i] - c[i];
      m    = mag(w[i]);
      s2   = s2 + {64'd0, m} * {64'd0, m};
    end
    len = isqrt128(s2 << 60);
    for (int i = 0; i < 3; i++) nrm[i] = '0;
    if (len != 0) begin
      for (int i = 0; i < 3; i++) begin
        q  = (({64'd0, mag(w[i])} << 44) + {65'd0, len[63:1]}) / {64'd0, len};
        nv = q[63:0];
        if (w[i] < 0) nv = -nv;
        nrm[i] = nv[15:0];
      end
    end
    r.normal_x = nrm[0];
    r.normal_y = nrm[1];
    r.normal_z = nrm[2];
    return r;
  endfunction

  task automatic check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      $error("field %s: expected %0d, actual %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  // track registers, queue predictions, compare results
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      sph_cx     = 0;
      sph_cy     = 0;
      sph_cz     = 0;
      sph_rad    = RADIUS_RST;
      fail_count = 0;
      hits_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CENTER_X: sph_cx = $signed(cfg_data);
          CFG_CENTER_Y: sph_cy = $signed(cfg_data);
          CFG_CENTER_Z: sph_cz = $signed(cfg_data);
          CFG_RADIUS:   sph_rad = cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) hits_due.push_back(intersect_ray(in_data));
      if (out_valid && out_ready) begin
        if (hits_due.size() == 0) begin
          $error("result transaction with no ray outstanding");
          fail_count++;
        end else begin
          want = hits_due.pop_front();
          check_field("hit", want.hit, out_data.hit);
          check_field("hit_x", want.hit_x, out_data.hit_x);
          check_field("hit_y", want.hit_y, out_data.hit_y);
          check_field("hit_z", want.hit_z, out_data.hit_z);
          check_field("normal_x", want.normal_x, out_data.normal_x);
          check_field("normal_y", want.normal_y, out_data.normal_y);
          check_field("normal_z", want.normal_z, out_data.normal_z);
        end
      end
    end
    pending = hits_due.size();
  end

endmodule

/* sim/ray_sphere_intersect_tb.sv */
// ----------------------------------------------------------------------------
// ray_sphere_intersect_tb: stimulus and verdict for ray_sphere_intersect
// Drives directed and random rays over several sphere settings with bursty
// input and a stalling receiver; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb;
  import rsi_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  // generator's view of the sphere
  longint cur_cx, cur_cy, cur_cz, cur_rad;
  int     burst_left;
  bit     no_gaps;
  bit     hold_req;

  ray_sphere_intersect uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ray_sphere_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: windowed stall patterns, plus a long hold on request
  initial begin
    int mode;
    int cnt;
    out_ready <= 1'b0;
    mode = 0;
    cnt  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (cnt % 64 == 0) mode = $urandom_range(0, 3);
        cnt++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 9) == 0);
          default: out_ready <= (cnt % 3 != 0);
        endcase
      end
    end
  end

  function automatic in_t mk_ray(longint ox, longint oy, longint oz,
                                 longint dx, longint dy, longint dz);
    in_t r;
    r.origin_x = 32'(ox); r.origin_y = 32'(oy); r.origin_z = 32'(oz);
    r.dir_x    = 32'(dx); r.dir_y    = 32'(dy); r.dir_z    = 32'(dz);
    return r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint spread_rand(longint span);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return longint'(raw % (2 * span + 1)) - span;
  endfunction

  // random ray: mostly aimed near the sphere, some pure noise
  function automatic in_t random_ray();
    longint o[3], d[3], c[3], span;
    int     sh;
    in_t    r;
    if ($urandom_range(0, 9) < 2) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    c[0] = cur_cx; c[1] = cur_cy; c[2] = cur_cz;
    span = cur_rad * 3 + 65536 * $urandom_range(1, 8);
    sh   = $urandom_range(0, 10);
    for (int i = 0; i < 3; i++) begin
      o[i] = clamp32(c[i] + spread_rand(span));
      d[i] = (c[i] - o[i]) + spread_rand(cur_rad / 2 + 1);
      if ($urandom_range(0, 7) == 0) d[i] = -d[i];
      d[i] = clamp32(d[i] >>> sh);
    end
    return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endfunction

  // one register transaction; valid stays high across a series of writes
  task automatic write_reg(cfg_idx_t idx, longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[31:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_sphere(longint cx, longint cy, longint cz, longint rad);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, rad);
    cfg_valid <= 1'b0;
    cur_cx = cx; cur_cy = cy; cur_cz = cz; cur_rad = rad;
  endtask

  // one ray transaction; valid stays high inside a burst
  task automatic send_ray(in_t ray);
    in_valid <= 1'b1;
    in_data  <= ray;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  // let every result drain, then allow the pipeline to go quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (220) @(posedge clk);
  endtask

  task automatic random_rays(int count);
    for (int k = 0; k < count; k++) send_ray(random_ray());
  endtask

  localparam longint ONE = 65536;

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    hold_req   = 1'b0;
    no_gaps    = 1'b0;
    burst_left = 5;
    cur_cx = 0; cur_cy = 0; cur_cz = 0; cur_rad = RADIUS_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rays against the reset sphere
    send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, ONE));           // plain hit
    send_ray(mk_ray(0, 0, 0, ONE, 0, 0));                  // inside: far root
    send_ray(mk_ray(ONE, 0, -3 * ONE, 0, 0, ONE));         // tangent
    send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, 0));             // zero direction
    send_ray(mk_ray(0, 0, 3 * ONE, 0, 0, ONE));            // sphere behind
    send_ray(mk_ray(5 * ONE, 0, -3 * ONE, 0, 0, ONE));     // no real root
    send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, 2147483647));
    send_ray(mk_ray(0, 0, 3 * ONE, 0, 0, -2147483648));
    send_ray(mk_ray(2147483647, 2147483647, 2147483647,
                    2147483647, 2147483647, 2147483647));
    send_ray(mk_ray(-2147483648, -2147483648, -2147483648,
                    -2147483648, -2147483648, -2147483648));
    send_ray(mk_ray(-2147483648, -2147483648, -2147483648,
                    2147483647, 2147483647, 2147483647));
    send_ray(mk_ray(-1, -1, -1, 1, 1, 1));
    random_rays(260);
    drain();

    // radius zero: hit lands on the center
    set_sphere(0, 0, 0, 0);
    send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, ONE));
    send_ray(mk_ray(ONE, ONE, ONE, -1, -1, -1));
    send_ray(mk_ray(ONE, 0, 0, ONE, 0, 0));
    random_rays(100);
    drain();

    // far corner center, largest radius; saturated hit points
    set_sphere(2147483647, -2147483648, 305419896, 2147483647);
    send_ray(mk_ray(0, 0, 0, ONE, -ONE, 0));
    send_ray(mk_ray(2147483647, -2147483648, 305419896, 2147483647, 0, 0));
    send_ray(mk_ray(0, 0, 0, 2147483647, -2147483648, 0));
    random_rays(220);
    drain();

    // long receiver hold while rays keep coming: pipeline fills
    set_sphere(-5 * ONE, 7 * ONE, 2 * ONE, 3 * ONE);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    random_rays(300);
    no_gaps = 1'b0;
    drain();

    // more random settings
    for (int ph = 0; ph < 4; ph++) begin
      set_sphere(spread_rand(64'd1 << 26), spread_rand(64'd1 << 26),
                 spread_rand(64'd1 << 26),
                 (ph == 3) ? $urandom_range(1, 2147483647) :
                             $urandom_range(ONE / 4, 64 * ONE));
      random_rays(215);
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
